FILE: sv/cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_pkg: shared types for the compacting array list
// Request and response payloads, kind and status codes, cell control.
// ----------------------------------------------------------------------------
package cal_pkg;

  localparam int DefCapacity = 32;
  localparam int WordW       = 32;
  localparam int IndexW      = 5;
  localparam int CountW      = 6;

  typedef enum logic [1:0] {
    KIND_APPEND    = 2'd0,
    KIND_REMOVE_TL = 2'd1,
    KIND_REMOVE_AT = 2'd2,
    KIND_READ_AT   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [WordW-1:0]  value;
    logic [IndexW-1:0]        index;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WordW-1:0]  data;
    logic [CountW-1:0]        count;
  } rsp_t;

  // Per-cell update command
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: sv/cal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_cell: one list entry
// Holds one word; loads an appended word or takes its upper neighbor's word.
// ----------------------------------------------------------------------------
module cal_cell (
  input  logic                            clk_i,
  input  cal_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [cal_pkg::WordW-1:0] value_i,
  input  logic signed [cal_pkg::WordW-1:0] neighbor_i,
  output logic signed [cal_pkg::WordW-1:0] entry_o
);
  import cal_pkg::*;

  logic signed [WordW-1:0] entry_q, entry_d;

  // Pick the next word: shift down wins, append loads, otherwise hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = neighbor_i;
    end else if (ctrl_i.load) begin
      entry_d = value_i;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/compacting_array_list.sv
`timescale 1ns / 1ps
// Result: registered; it appears in the cycle after its request transfer, for one cycle.
// Throughput: one request per cycle; busy stays low, since every kind,
// including remove at index, finishes in the single update of the cell row.
// Reset: the list is empty after reset; entry words are not cleared.
// The receiver cannot stall: done_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
// compacting_array_list: fixed-capacity ordered list of signed words
// A row of entry cells; remove at index shifts every later cell down at once.
// ----------------------------------------------------------------------------
module compacting_array_list #(
  parameter int CAPACITY = cal_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cal_pkg::req_t req_i,
  output logic          done_o,
  output cal_pkg::rsp_t rsp_o
);
  import cal_pkg::*;

  localparam int FillW = $clog2(CAPACITY + 1);
  localparam int CmpW  = (FillW > IndexW) ? FillW : IndexW;
  localparam int ExtW  = (FillW > CountW) ? FillW : CountW;

  logic [FillW-1:0] fill_q, fill_d;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;

  logic             xfer;
  logic             full, empty, idx_ok;
  logic [CmpW-1:0]  idx_ext, fill_ext;
  logic             do_append, do_remove_at;
  logic [ExtW-1:0]  fill_wide;
  logic signed [WordW-1:0] rd_data;

  logic signed [WordW-1:0] entries [CAPACITY];
  cell_ctrl_t              ctrl    [CAPACITY];

  assign busy = 1'b0;
  assign xfer = start && !busy;

  assign full     = (fill_q == FillW'(CAPACITY));
  assign empty    = (fill_q == '0);
  assign idx_ext  = CmpW'(req_i.index);
  assign fill_ext = CmpW'(fill_q);
  assign idx_ok   = (idx_ext < fill_ext);

  assign do_append    = xfer && (req_i.kind == KIND_APPEND) && !full;
  assign do_remove_at = xfer && (req_i.kind == KIND_REMOVE_AT) && idx_ok;

  // Build the row of cells; each decides its own update from its position
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [WordW-1:0] nbr;
    if (j == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entries[j+1];
    end

    assign ctrl[j].load  = do_append && (fill_q == FillW'(j));
    assign ctrl[j].shift = do_remove_at && (CmpW'(j) >= idx_ext);

    cal_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[j]),
      .value_i    (req_i.value),
      .neighbor_i (nbr),
      .entry_o    (entries[j])
    );
  end

  // Select the addressed entry
  always_comb begin
    rd_data = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (idx_ext == CmpW'(j)) begin
        rd_data = rd_data | entries[j];
      end
    end
  end

  // Decide status, new fill and response
  always_comb begin
    fill_d       = fill_q;
    rsp_d.status = STATUS_OK;
    rsp_d.data   = '0;
    case (req_i.kind)
      KIND_APPEND: begin
        if (full) begin
          rsp_d.status = STATUS_FULL;
        end else begin
          fill_d = fill_q + FillW'(1);
        end
      end
      KIND_REMOVE_TL: begin
        if (empty) begin
          rsp_d.status = STATUS_EMPTY;
        end else begin
          fill_d = fill_q - FillW'(1);
        end
      end
      KIND_REMOVE_AT: begin
        if (empty) begin
          rsp_d.status = STATUS_EMPTY;
        end else if (!idx_ok) begin
          rsp_d.status = STATUS_BADIDX;
        end else begin
          fill_d = fill_q - FillW'(1);
        end
      end
      KIND_READ_AT: begin
        if (!idx_ok) begin
          rsp_d.status = STATUS_BADIDX;
        end else begin
          rsp_d.data = rd_data;
        end
      end
      default: begin
        rsp_d.status = STATUS_OK;
      end
    endcase
    fill_wide   = ExtW'(fill_d);
    rsp_d.count = fill_wide[CountW-1:0];
  end

  // Control registers: fill and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= xfer;
      if (xfer) begin
        fill_q <= fill_d;
      end
    end
  end

  // Hold the response for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: sv/cal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_checker: port-level checks for the compacting array list
// Watches request transfers and result strobes on the top-level ports.
// ----------------------------------------------------------------------------
module cal_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input cal_pkg::req_t req_i,
  input logic          done_o,
  input cal_pkg::rsp_t rsp_o
);
  import cal_pkg::*;

  // Every transfer gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("transfer without result");

  // No result without a transfer before it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without transfer");

  // Back-to-back results move the count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      ((rsp_o.count == $past(rsp_o.count)) ||
       (rsp_o.count == CountW'($past(rsp_o.count) + CountW'(1))) ||
       (CountW'(rsp_o.count + CountW'(1)) == $past(rsp_o.count))))
    else $error("count jumped");

  // Nonzero data only comes from a good read
  a_data_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.data != '0)) |->
      ((rsp_o.status == STATUS_OK) && ($past(req_i.kind) == KIND_READ_AT)))
    else $error("data on a non-read result");

endmodule

bind compacting_array_list cal_checker u_cal_checker (.*);
